// ===== src/adcs_pkg.sv =====
// shared types, codes and helpers for the adc channel sequencer
package adcs_pkg;

	// fixed widths of the register and word fields
	localparam int MODES_W     = 10;
	localparam int SEL_REG_W   = 20;
	localparam int MODE_W      = 2;
	localparam int SEL_W       = 4;
	localparam int CMD_W       = 3;
	localparam int EIDX_W      = 3;
	localparam int SAMPLE_W    = 10;
	localparam int CNT_W       = 16;
	localparam int RUN_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;

	// entry count range and default
	localparam int NUM_ENTRIES_DEF = 5;
	localparam int MAX_ENTRIES     = 16;
	localparam int MAX_IDX_W       = 4;
	localparam int MODES_EXT_W     = MODE_W * MAX_ENTRIES;
	localparam int SEL_EXT_W       = SEL_W * MAX_ENTRIES;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 3'd0,
		CMD_DONE  = 3'd1,
		CMD_TRIG  = 3'd2,
		CMD_ARM   = 3'd3,
		CMD_STOP  = 3'd4,
		CMD_READ  = 3'd5
	} cmd_t;

	typedef enum logic [RUN_W-1:0] {
		RUN_STOPPED  = 2'd0,
		RUN_STARTED  = 2'd1,
		RUN_PENDING  = 2'd2,
		RUN_COMPLETE = 2'd3
	} run_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF     = 2'd0,
		MODE_CONT    = 2'd1,
		MODE_ONESHOT = 2'd2,
		MODE_RSVD    = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODES    = 2'd0,
		REG_CHANNELS = 2'd1,
		REG_TRIGGERS = 2'd2
	} reg_t;

	localparam logic [SEL_W-1:0] TRIG_IMMEDIATE = 4'h0;
	localparam logic [SEL_W-1:0] SEL_MASK       = 4'hF;

	// write strobes from the sequencer to the entry store
	typedef struct packed {
		logic                 store_en;
		logic [MAX_IDX_W-1:0] store_idx;
		logic                 arm_en;
		logic [MAX_IDX_W-1:0] arm_idx;
	} store_ctl_t;

	// outcome of one step of the scan unit
	typedef struct packed {
		logic [MAX_IDX_W-1:0] nxt_idx;
		logic                 wrap;
		logic                 eligible;
		logic [SEL_W-1:0]     chan;
		logic [SEL_W-1:0]     trig;
	} scan_res_t;

endpackage

// ===== src/adcs_if.sv =====
// valid/ready channel interfaces of the adc channel sequencer
interface adcs_in_if
	import adcs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [EIDX_W-1:0]   entry_index;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, command, entry_index, sample, input ready);
	modport sink (input valid, command, entry_index, sample, output ready);
endinterface

interface adcs_out_if
	import adcs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                conversion_setup;
	logic [SEL_W-1:0]    channel_select;
	logic [SEL_W-1:0]    trigger_select;
	logic [EIDX_W-1:0]   current_index;
	logic [RUN_W-1:0]    converter_state;
	logic [SAMPLE_W-1:0] read_value;
	logic                read_sampled;
	logic                read_armed;
	logic [CNT_W-1:0]    conversions_done;
	logic [CNT_W-1:0]    full_cycles;

	modport source (
		output valid, conversion_setup, channel_select, trigger_select, current_index,
		       converter_state, read_value, read_sampled, read_armed, conversions_done,
		       full_cycles,
		input  ready
	);
	modport sink (
		input  valid, conversion_setup, channel_select, trigger_select, current_index,
		       converter_state, read_value, read_sampled, read_armed, conversions_done,
		       full_cycles,
		output ready
	);
endinterface

interface adcs_cfg_if
	import adcs_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/adc_channel_sequencer.sv =====
// top level of the adc channel sequencer: command sequencer, counters and result register
//
// Round-robin conversion scheduler over NUM_ENTRIES measurement entries. Each
// word on the command channel gives exactly one result word. Start words, and
// conversion-done words while a conversion runs, run a scan that walks the
// entries one per clock through a single shared step unit (increment with
// wrap, mode/arm test, channel and trigger pick), starting after the current
// index and checking the current entry last; it stops at the first eligible
// entry or after a full lap. Trigger, arm, stop, read and ignored commands go
// from idle straight to the done state; a scan passes through the scan state,
// one step per entry visited, before it. In the done state the result is
// loaded into the output register as soon as that is free. The command
// channel is not ready while a word is in work. A loaded result waits in the
// output register and the next command word may be taken meanwhile; a second
// result waits until the first one is taken. Configuration writes are always
// ready and must only be made while no command is in work. No clearing pass
// follows reset.
module adc_channel_sequencer
	import adcs_pkg::*;
#(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	adcs_in_if.sink    in,
	adcs_out_if.source out,
	adcs_cfg_if.sink   cfg
);

	localparam int IDX_W = $clog2(NUM_ENTRIES);
	localparam int IDX_CMP_W = MAX_IDX_W + 1;
	localparam logic [IDX_CMP_W-1:0] NUM_ENTRIES_C = IDX_CMP_W'(NUM_ENTRIES);

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} seq_state_t;

	seq_state_t state_q;

	// configuration registers
	logic [MODES_W-1:0]   modes_q;
	logic [SEL_REG_W-1:0] channels_q;
	logic [SEL_REG_W-1:0] triggers_q;

	// scheduler state and counters
	logic [IDX_W-1:0] sched_q;
	logic [IDX_W-1:0] scan_idx_q;
	run_t             run_q;
	logic [CNT_W-1:0] done_cnt_q;
	logic [CNT_W-1:0] cycle_cnt_q;

	// result being built for the current word
	logic                res_setup_q;
	logic [SEL_W-1:0]    res_chan_q;
	logic [SEL_W-1:0]    res_trig_q;
	logic [SAMPLE_W-1:0] res_rd_value_q;
	logic                res_rd_sampled_q;
	logic                res_rd_armed_q;

	// output register
	logic                out_valid_q;
	logic                out_setup_q;
	logic [SEL_W-1:0]    out_chan_q;
	logic [SEL_W-1:0]    out_trig_q;
	logic [EIDX_W-1:0]   out_index_q;
	logic [RUN_W-1:0]    out_state_q;
	logic [SAMPLE_W-1:0] out_rd_value_q;
	logic                out_rd_sampled_q;
	logic                out_rd_armed_q;
	logic [CNT_W-1:0]    out_done_q;
	logic [CNT_W-1:0]    out_cycles_q;

	logic                   in_fire;
	logic                   out_load;
	logic [IDX_CMP_W-1:0]   in_idx_ext;
	logic                   in_idx_ok;
	logic [IDX_W-1:0]       in_idx;
	store_ctl_t             store_ctl;
	logic [SAMPLE_W-1:0]    rd_value;
	logic                   rd_sampled;
	logic                   rd_armed;
	logic [NUM_ENTRIES-1:0] armed;
	scan_res_t              step;
	logic [IDX_W-1:0]       step_idx;

	assign in.ready  = (state_q == ST_IDLE);
	assign in_fire   = in.valid && in.ready;
	assign cfg.ready = 1'b1;

	// addressed entry of arm and read; out of range arms nothing, reads zeros
	assign in_idx_ext = IDX_CMP_W'(in.entry_index);
	assign in_idx_ok  = (in_idx_ext < NUM_ENTRIES_C);
	assign in_idx     = in_idx_ext[IDX_W-1:0];

	// conversion done stores the sample at the current entry before the scan
	always_comb begin
		store_ctl           = '0;
		store_ctl.store_idx = MAX_IDX_W'(sched_q);
		store_ctl.arm_idx   = MAX_IDX_W'(in_idx);
		if (in_fire) begin
			store_ctl.store_en = (in.command == CMD_DONE) && (run_q == RUN_STARTED);
			store_ctl.arm_en   = (in.command == CMD_ARM) && in_idx_ok;
		end
	end

	adcs_entry_store #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.IDX_W       (IDX_W)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (store_ctl),
		.sample     (in.sample),
		.rd_idx     (in_idx),
		.rd_value   (rd_value),
		.rd_sampled (rd_sampled),
		.rd_armed   (rd_armed),
		.armed      (armed)
	);

	adcs_scan_unit #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.IDX_W       (IDX_W)
	) u_scan (
		.idx      (scan_idx_q),
		.modes    (modes_q),
		.channels (channels_q),
		.triggers (triggers_q),
		.armed    (armed),
		.res      (step)
	);

	assign step_idx = step.nxt_idx[IDX_W-1:0];

	// result register is free when empty or being taken this cycle
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out.ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q    <= '0;
			channels_q <= '0;
			triggers_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODES:    modes_q    <= cfg.data[MODES_W-1:0];
				REG_CHANNELS: channels_q <= cfg.data[SEL_REG_W-1:0];
				REG_TRIGGERS: triggers_q <= cfg.data[SEL_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sched_q     <= '0;
			scan_idx_q  <= '0;
			run_q       <= RUN_STOPPED;
			done_cnt_q  <= '0;
			cycle_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						scan_idx_q <= sched_q;
						case (in.command)
							CMD_START: begin
								done_cnt_q  <= '0;
								cycle_cnt_q <= '0;
								state_q     <= ST_SCAN;
							end
							CMD_DONE: begin
								// ignored unless a conversion is running
								if (run_q == RUN_STARTED) begin
									done_cnt_q <= done_cnt_q + 1'b1;
									state_q    <= ST_SCAN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							CMD_TRIG: begin
								if (run_q == RUN_PENDING) begin
									run_q <= RUN_STARTED;
								end
								state_q <= ST_DONE;
							end
							CMD_STOP: begin
								run_q   <= RUN_STOPPED;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					// one entry per cycle; current entry is the last one visited
					scan_idx_q <= step_idx;
					if (step.wrap) begin
						cycle_cnt_q <= cycle_cnt_q + 1'b1;
					end
					if (step.eligible) begin
						sched_q <= step_idx;
						run_q   <= (step.trig == TRIG_IMMEDIATE) ? RUN_STARTED : RUN_PENDING;
						state_q <= ST_DONE;
					end else if (step_idx == sched_q) begin
						run_q   <= RUN_STOPPED;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-word result fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_setup_q <= 1'b0;
			res_chan_q  <= '0;
			res_trig_q  <= '0;
			if ((in.command == CMD_READ) && in_idx_ok) begin
				res_rd_value_q   <= rd_value;
				res_rd_sampled_q <= rd_sampled;
				res_rd_armed_q   <= rd_armed;
			end else begin
				res_rd_value_q   <= '0;
				res_rd_sampled_q <= 1'b0;
				res_rd_armed_q   <= 1'b0;
			end
		end else if ((state_q == ST_SCAN) && step.eligible) begin
			res_setup_q <= 1'b1;
			res_chan_q  <= step.chan;
			res_trig_q  <= step.trig;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_setup_q      <= res_setup_q;
			out_chan_q       <= res_chan_q;
			out_trig_q       <= res_trig_q;
			out_index_q      <= EIDX_W'(sched_q);
			out_state_q      <= run_q;
			out_rd_value_q   <= res_rd_value_q;
			out_rd_sampled_q <= res_rd_sampled_q;
			out_rd_armed_q   <= res_rd_armed_q;
			out_done_q       <= done_cnt_q;
			out_cycles_q     <= cycle_cnt_q;
		end
	end

	assign out.valid            = out_valid_q;
	assign out.conversion_setup = out_setup_q;
	assign out.channel_select   = out_chan_q;
	assign out.trigger_select   = out_trig_q;
	assign out.current_index    = out_index_q;
	assign out.converter_state  = out_state_q;
	assign out.read_value       = out_rd_value_q;
	assign out.read_sampled     = out_rd_sampled_q;
	assign out.read_armed       = out_rd_armed_q;
	assign out.conversions_done = out_done_q;
	assign out.full_cycles      = out_cycles_q;

endmodule

// ===== src/adcs_entry_store.sv =====
// per-entry sample value, sampled flag and arm flag
module adcs_entry_store
	import adcs_pkg::*;
#(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
	parameter int IDX_W       = $clog2(NUM_ENTRIES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  store_ctl_t             ctl,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic [IDX_W-1:0]       rd_idx,
	output logic [SAMPLE_W-1:0]    rd_value,
	output logic                   rd_sampled,
	output logic                   rd_armed,
	output logic [NUM_ENTRIES-1:0] armed
);

	logic [SAMPLE_W-1:0]    value_q [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] sampled_q;
	logic [NUM_ENTRIES-1:0] armed_q;
	logic [IDX_W-1:0]       st_idx;
	logic [IDX_W-1:0]       arm_idx;

	assign st_idx  = ctl.store_idx[IDX_W-1:0];
	assign arm_idx = ctl.arm_idx[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				value_q[i] <= '0;
			end
			sampled_q <= '0;
			armed_q   <= '0;
		end else begin
			if (ctl.store_en) begin
				value_q[st_idx]   <= sample;
				sampled_q[st_idx] <= 1'b1;
				armed_q[st_idx]   <= 1'b0;
			end
			if (ctl.arm_en) begin
				armed_q[arm_idx] <= 1'b1;
			end
		end
	end

	assign rd_value   = value_q[rd_idx];
	assign rd_sampled = sampled_q[rd_idx];
	assign rd_armed   = armed_q[rd_idx];
	assign armed      = armed_q;

endmodule

// ===== src/adcs_scan_unit.sv =====
// one scan step: advance the index with wrap, test eligibility, pick selects
module adcs_scan_unit
	import adcs_pkg::*;
#(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
	parameter int IDX_W       = $clog2(NUM_ENTRIES)
) (
	input  logic [IDX_W-1:0]       idx,
	input  logic [MODES_W-1:0]     modes,
	input  logic [SEL_REG_W-1:0]   channels,
	input  logic [SEL_REG_W-1:0]   triggers,
	input  logic [NUM_ENTRIES-1:0] armed,
	output scan_res_t              res
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

	logic [IDX_W-1:0]       nxt;
	logic                   wrap;
	logic [MODES_EXT_W-1:0] modes_ext;
	logic [SEL_EXT_W-1:0]   chan_ext;
	logic [SEL_EXT_W-1:0]   trig_ext;
	logic [MODE_W-1:0]      mode;

	// entries past a register's width read as zero
	assign modes_ext = MODES_EXT_W'(modes);
	assign chan_ext  = SEL_EXT_W'(channels);
	assign trig_ext  = SEL_EXT_W'(triggers);

	assign wrap = (idx == LAST_IDX);
	assign nxt  = wrap ? '0 : idx + 1'b1;
	assign mode = modes_ext[MODE_W*nxt +: MODE_W];

	always_comb begin
		res          = '0;
		res.nxt_idx  = MAX_IDX_W'(nxt);
		res.wrap     = wrap;
		res.eligible = (mode == MODE_CONT) || ((mode == MODE_ONESHOT) && armed[nxt]);
		res.chan     = chan_ext[SEL_W*nxt +: SEL_W] & SEL_MASK;
		res.trig     = trig_ext[SEL_W*nxt +: SEL_W] & SEL_MASK;
	end

endmodule

// ===== test/adc_channel_sequencer_tb.sv =====
// self-checking testbench for the adc channel sequencer: directed words, then random phases
module adc_channel_sequencer_tb
	import adcs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// the block is built with its default entry count
	localparam int N_ENT = NUM_ENTRIES_DEF;

	// command codes the block has no operation for
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	// longest per-word wait on either side
	localparam int GAP_MAX = 11;
	// settle wait: long enough for a scan over every entry, plus margin
	localparam int SETTLE_CYCLES = 2 + N_ENT + 1;
	// cycles with no handshake on any channel before the run is declared hung
	localparam int STALL_LIMIT = 2000;

	// directed setting: continuous, one-shot, continuous, reserved, one-shot
	localparam logic [MODES_W-1:0]    DIR_MODES = 10'h2D9;
	localparam logic [SEL_REG_W-1:0]  DIR_CHANS = 20'h9A5F0;
	// entry 0 immediate, the rest wait on a trigger
	localparam logic [SEL_REG_W-1:0]  DIR_TRIGS = 20'h37F50;

	// one result word as seen on the output channel
	typedef struct packed {
		logic                setup;
		logic [SEL_W-1:0]    chan;
		logic [SEL_W-1:0]    trig;
		logic [EIDX_W-1:0]   cur_idx;
		logic [RUN_W-1:0]    state;
		logic [SAMPLE_W-1:0] rd_value;
		logic                rd_sampled;
		logic                rd_armed;
		logic [CNT_W-1:0]    done_cnt;
		logic [CNT_W-1:0]    lap_cnt;
	} seq_result_t;

	// sequencer state mirror plus the queue of result words still owed by the block
	class sequencer_scoreboard;
		logic [MODES_W-1:0]   modes;
		logic [SEL_REG_W-1:0] chans;
		logic [SEL_REG_W-1:0] trigs;
		int unsigned          sched_idx;
		run_t                 run;
		logic [SAMPLE_W-1:0]  value [N_ENT];
		bit                   sampled [N_ENT];
		bit                   armed [N_ENT];
		logic [CNT_W-1:0]     done_cnt;
		logic [CNT_W-1:0]     lap_cnt;
		seq_result_t          expected_q [$];
		int unsigned          errors, n_words, n_results, n_setups, n_stored, n_dry_scans;
		int unsigned          n_reads, n_configs;

		function new();
			modes = '0;
			chans = '0;
			trigs = '0;
			sched_idx = 0;
			run = RUN_STOPPED;
			for (int i = 0; i < N_ENT; i++) begin
				value[i] = '0;
				sampled[i] = 1'b0;
				armed[i] = 1'b0;
			end
			done_cnt = '0;
			lap_cnt = '0;
			errors = 0;
			n_words = 0;
			n_results = 0;
			n_setups = 0;
			n_stored = 0;
			n_dry_scans = 0;
			n_reads = 0;
			n_configs = 0;
		endfunction

		function void write_reg(reg_t r, logic [CFG_DATA_W-1:0] d);
			case (r)
				REG_MODES:    modes = d[MODES_W-1:0];
				REG_CHANNELS: chans = d;
				REG_TRIGGERS: trigs = d;
				default: ;
			endcase
		endfunction

		// continuous entries always qualify, one-shot ones only while armed
		function bit entry_ready(int unsigned i);
			mode_t m;
			m = mode_t'(modes[MODE_W*i +: MODE_W]);
			if (m == MODE_CONT)
				return 1'b1;
			if (m == MODE_ONESHOT)
				return armed[i];
			return 1'b0;
		endfunction

		// walk forward from the current entry, current one last, counting wraps
		function bit scan_next(output logic [SEL_W-1:0] ch, output logic [SEL_W-1:0] tr);
			int unsigned k;
			k = sched_idx;
			ch = '0;
			tr = '0;
			for (int n = 0; n < N_ENT; n++) begin
				k++;
				if (k >= N_ENT) begin
					k = 0;
					lap_cnt++;
				end
				if (entry_ready(k)) begin
					sched_idx = k;
					ch = chans[SEL_W*k +: SEL_W];
					tr = trigs[SEL_W*k +: SEL_W];
					run = (tr == TRIG_IMMEDIATE) ? RUN_STARTED : RUN_PENDING;
					n_setups++;
					return 1'b1;
				end
				if (k == sched_idx)
					break;
			end
			sched_idx = k;
			run = RUN_STOPPED;
			n_dry_scans++;
			return 1'b0;
		endfunction

		// apply one accepted command word; returns 0 when the block just ignores it
		function bit note_command(logic [CMD_W-1:0] c, logic [EIDX_W-1:0] e,
				logic [SAMPLE_W-1:0] s);
			seq_result_t      r;
			bit               acted;
			logic [SEL_W-1:0] ch, tr;
			r = '0;
			acted = 1'b1;
			ch = '0;
			tr = '0;
			case (c)
				CMD_START: begin
					done_cnt = '0;
					lap_cnt = '0;
					r.setup = scan_next(ch, tr);
				end
				CMD_DONE: begin
					if (run == RUN_STARTED) begin
						done_cnt++;
						value[sched_idx] = s;
						armed[sched_idx] = 1'b0;
						sampled[sched_idx] = 1'b1;
						n_stored++;
						r.setup = scan_next(ch, tr);
					end else
						acted = 1'b0;
				end
				CMD_TRIG: begin
					if (run == RUN_PENDING)
						run = RUN_STARTED;
					else
						acted = 1'b0;
				end
				CMD_ARM: begin
					if (e < N_ENT)
						armed[e] = 1'b1;
					else
						acted = 1'b0;
				end
				CMD_STOP: run = RUN_STOPPED;
				CMD_READ: begin
					n_reads++;
					if (e < N_ENT) begin
						r.rd_value = value[e];
						r.rd_sampled = sampled[e];
						r.rd_armed = armed[e];
					end
				end
				default: acted = 1'b0;
			endcase
			if (r.setup) begin
				r.chan = ch;
				r.trig = tr;
			end
			r.cur_idx = sched_idx[EIDX_W-1:0];
			r.state = run;
			r.done_cnt = done_cnt;
			r.lap_cnt = lap_cnt;
			expected_q.push_back(r);
			n_words++;
			return acted;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (got !== want)
				report($sformatf("result word %0d, %s: expected %0h, got %0h",
					n_results, name, want, got));
		endtask

		task check_result(seq_result_t got);
			seq_result_t want;
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("result word %0d with nothing expected (%h)", n_results, got));
				return;
			end
			want = expected_q.pop_front();
			check_field("conversion_setup", want.setup, got.setup);
			check_field("channel_select", want.chan, got.chan);
			check_field("trigger_select", want.trig, got.trig);
			check_field("current_index", want.cur_idx, got.cur_idx);
			check_field("converter_state", want.state, got.state);
			check_field("read_value", want.rd_value, got.rd_value);
			check_field("read_sampled", want.rd_sampled, got.rd_sampled);
			check_field("read_armed", want.rd_armed, got.rd_armed);
			check_field("conversions_done", want.done_cnt, got.done_cnt);
			check_field("full_cycles", want.lap_cnt, got.lap_cnt);
		endtask
	endclass

	logic clk;
	logic arst_n;

	adcs_in_if  in_ch ();
	adcs_out_if out_ch ();
	adcs_cfg_if cfg_ch ();

	adc_channel_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch),
		.cfg    (cfg_ch)
	);

	sequencer_scoreboard sb = new();

	// per-word wait limits of the command sender and the result receiver
	int unsigned in_gap_max = GAP_MAX;
	int unsigned out_gap_max = GAP_MAX;
	int unsigned stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// offer one command word after a random gap, return once it is taken
	// valid is only lowered when a gap follows, so back-to-back words keep it high
	task send_word(logic [CMD_W-1:0] c, logic [EIDX_W-1:0] e, logic [SAMPLE_W-1:0] s,
			output bit acted);
		int unsigned gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= c;
		in_ch.entry_index <= e;
		in_ch.sample <= s;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		acted = sb.note_command(c, e, s);
	endtask

	// directed words where the outcome flag is of no interest
	task send(logic [CMD_W-1:0] c, logic [EIDX_W-1:0] e, logic [SAMPLE_W-1:0] s);
		bit acted;
		send_word(c, e, s, acted);
	endtask

	// hold off new commands until every owed result word is back, then let the scan settle
	task drain();
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers back to back, only called while the block is idle
	task set_config(logic [MODES_W-1:0] m, logic [SEL_REG_W-1:0] ch,
			logic [SEL_REG_W-1:0] tr);
		reg_t                  regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs[0] = REG_MODES;
		regs[1] = REG_CHANNELS;
		regs[2] = REG_TRIGGERS;
		vals[0] = CFG_DATA_W'(m);
		vals[1] = ch;
		vals[2] = tr;
		cfg_ch.valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_ch.index <= regs[i];
			cfg_ch.data <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			sb.write_reg(regs[i], vals[i]);
		end
		cfg_ch.valid <= 1'b0;
		sb.n_configs++;
	endtask

	// random trigger nibbles, about half of them immediate
	function logic [SEL_REG_W-1:0] mixed_trigs();
		logic [SEL_REG_W-1:0] v;
		v = '0;
		for (int i = 0; i < SEL_REG_W / SEL_W; i++)
			if ($urandom_range(0, 1))
				v[SEL_W*i +: SEL_W] = SEL_W'($urandom_range(1, 15));
		return v;
	endfunction

	// one configuration phase: mostly well-formed command flow steered by the
	// mirrored run state, with some noise words mixed in
	task run_phase(logic [MODES_W-1:0] m, logic [SEL_REG_W-1:0] ch,
			logic [SEL_REG_W-1:0] tr, int unsigned in_max, int unsigned out_max,
			int unsigned target);
		int unsigned         useful, r;
		logic [CMD_W-1:0]    c;
		logic [EIDX_W-1:0]   e;
		logic [SAMPLE_W-1:0] s;
		bit                  acted;
		drain();
		set_config(m, ch, tr);
		in_gap_max = in_max;
		out_gap_max = out_max;
		useful = 0;
		while (useful < target) begin
			r = $urandom_range(0, 99);
			e = EIDX_W'($urandom_range(0, N_ENT - 1));
			s = SAMPLE_W'($urandom);
			if (r < 10) begin
				// noise: any code, any index including out of range
				c = CMD_W'($urandom_range(0, 7));
				e = EIDX_W'($urandom_range(0, 7));
			end else begin
				r = $urandom_range(0, 99);
				case (sb.run)
					RUN_STARTED: begin
						if (r < 70)      c = CMD_DONE;
						else if (r < 80) c = CMD_ARM;
						else if (r < 88) c = CMD_READ;
						else if (r < 93) c = CMD_START;
						else if (r < 97) c = CMD_TRIG;
						else             c = CMD_STOP;
					end
					RUN_PENDING: begin
						if (r < 70)      c = CMD_TRIG;
						else if (r < 80) c = CMD_READ;
						else if (r < 88) c = CMD_ARM;
						else if (r < 94) c = CMD_DONE;
						else             c = CMD_STOP;
					end
					default: begin
						if (r < 55)      c = CMD_START;
						else if (r < 85) c = CMD_ARM;
						else             c = CMD_READ;
					end
				endcase
			end
			send_word(c, e, s, acted);
			if (acted)
				useful++;
			// now and then let the pipeline run dry mid-phase
			if ($urandom_range(0, 79) == 0)
				drain();
		end
	endtask

	// result receiver: random ready gaps, compares every accepted word
	initial begin
		seq_result_t got;
		int unsigned gap;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, out_gap_max);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
			got.setup = out_ch.conversion_setup;
			got.chan = out_ch.channel_select;
			got.trig = out_ch.trigger_select;
			got.cur_idx = out_ch.current_index;
			got.state = out_ch.converter_state;
			got.rd_value = out_ch.read_value;
			got.rd_sampled = out_ch.read_sampled;
			got.rd_armed = out_ch.read_armed;
			got.done_cnt = out_ch.conversions_done;
			got.lap_cnt = out_ch.full_cycles;
			sb.check_result(got);
		end
	end

	// hang detector: any handshake on any channel restarts the count
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		// every block input known from time zero
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.command <= CMD_START;
		in_ch.entry_index <= '0;
		in_ch.sample <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_MODES;
		cfg_ch.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: every entry disabled, start laps once and stops
		send(CMD_START, 3'd0, '0);
		send(CMD_READ, 3'd0, '0);

		// mixed directed setting
		drain();
		set_config(DIR_MODES, DIR_CHANS, DIR_TRIGS);
		send(CMD_ARM, 3'd4, '0);
		// arm with an index past the last entry is dropped
		send(CMD_ARM, 3'd5, '0);
		send(CMD_ARM, 3'd7, '0);
		// unarmed one-shot skipped, lands on a continuous entry waiting for a trigger
		send(CMD_START, 3'd0, '0);
		// done while pending is ignored
		send(CMD_DONE, 3'd0, 10'h000);
		send(CMD_TRIG, 3'd0, '0);
		// trigger while already started is ignored
		send(CMD_TRIG, 3'd0, '0);
		// full-scale sample, scan skips the reserved mode entry to the armed one-shot
		send(CMD_DONE, 3'd0, 10'h3FF);
		send(CMD_TRIG, 3'd0, '0);
		// zero sample, one-shot disarms, scan wraps to the immediate entry
		send(CMD_DONE, 3'd0, 10'h000);
		send(CMD_READ, 3'd2, '0);
		send(CMD_READ, 3'd4, '0);
		// reads past the last entry answer zeros
		send(CMD_READ, 3'd5, '0);
		send(CMD_READ, 3'd7, '0);
		send(CMD_SPARE_LO, 3'd6, 10'h155);
		send(CMD_SPARE_HI, 3'd7, 10'h2AA);
		send(CMD_STOP, 3'd0, '0);
		// done and trigger while stopped change nothing
		send(CMD_DONE, 3'd1, 10'h3FF);
		send(CMD_TRIG, 3'd2, '0);
		send(CMD_ARM, 3'd1, '0);
		// restart clears both counters
		send(CMD_START, 3'd0, '0);
		send(CMD_DONE, 3'd3, 10'h155);
		send(CMD_STOP, 3'd0, '0);

		// random phases over a spread of settings and idling patterns
		run_phase(10'h155, 20'hFFFFF, 20'h00000, GAP_MAX, GAP_MAX, 300);
		run_phase(10'h2AA, SEL_REG_W'($urandom), 20'hFFFFF, 0, 0, 280);
		run_phase(MODES_W'($urandom), 20'h00000, mixed_trigs(), GAP_MAX, 0, 300);
		run_phase(10'h3FF, SEL_REG_W'($urandom), SEL_REG_W'($urandom), GAP_MAX, GAP_MAX, 40);
		// only the last entry enabled: every scan comes back around to itself
		run_phase(10'h100, SEL_REG_W'($urandom), mixed_trigs(), 0, GAP_MAX, 200);
		run_phase(MODES_W'($urandom), SEL_REG_W'($urandom), mixed_trigs(), GAP_MAX, GAP_MAX,
			450);
		run_phase(10'h000, 20'hFFFFF, 20'hFFFFF, GAP_MAX, GAP_MAX, 40);

		// let every owed result come back, then watch a little longer for strays
		drain();
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d result words never arrived", sb.expected_q.size()));

		$display("covered %0d command words and %0d result words over %0d register settings",
			sb.n_words, sb.n_results, sb.n_configs);
		$display("%0d conversions set up, %0d scans found nothing, %0d samples stored, %0d reads",
			sb.n_setups, sb.n_dry_scans, sb.n_stored, sb.n_reads);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/adcs_pkg.sv
src/adcs_if.sv
src/adcs_entry_store.sv
src/adcs_scan_unit.sv
src/adc_channel_sequencer.sv
test/adc_channel_sequencer_tb.sv
